@@ rtl/ftdos_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftdos_pkg
// Constants and helpers shared by the FILETIME to FAT date/time converter.
// ----------------------------------------------------------------------------
package ftdos_pkg;

    // tick counts for 1980-01-01 and 2038-01-01 UTC (ticks since 1601)
    localparam logic [63:0] FT_LO   = 64'd119600064000000000;
    localparam logic [63:0] FT_HI   = 64'd137903904000000000;
    localparam logic [63:0] FT_SPAN = 64'd18303840000000000;

    // constant divisors (for 1e7 and 86400 the power-of-two factor is taken out by shifts)
    localparam int DIV_SUBSEC = 78125;
    localparam int DIV_DAY    = 675;
    localparam int DIV_QUAD   = 1461;
    localparam int DIV_HOUR   = 3600;
    localparam int DIV_MIN    = 60;

    // day offsets of each year inside a leap-first four-year block
    localparam logic [10:0] QUAD_Y1 = 11'd366;
    localparam logic [10:0] QUAD_Y2 = 11'd731;
    localparam logic [10:0] QUAD_Y3 = 11'd1096;

    // edges from an accepted beat to the edge that takes its result
    localparam int PIPE_LAT = 21;

    typedef struct packed {
        logic       ok;
        logic [5:0] year_off;
        logic [8:0] doy;
        logic       leap;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] half_sec;
    } t_date_st;

    function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        unique case (mon)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && mon >= 4'd3) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage
`default_nettype wire

@@ rtl/filetime_to_dos_date_time.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// filetime_to_dos_date_time
// Converts a 64-bit count of 100 ns ticks since 1601 into FAT date/time words.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_file_time and pulse i_start; a beat is taken on every edge
//   where i_start is high and o_busy is low. o_busy is always low, so a new
//   beat may enter on every cycle.
//   Output: o_done is high for one cycle with o_fat_date, o_fat_time and
//   o_valid_res. Results come out in input order, one per input beat.
//   Throughput: one beat per cycle. The pipeline depth is set by the chain of
//   constant dividers (1e7, 86400, the four-year block, 3600, 60) retiring
//   four to six quotient bits a stage. Times before 1980 or from 2038 on
//   give o_valid_res low and zero words.
//   Reset: synchronous, active low; clears all valid bits, so beats in flight
//   are dropped and no o_done follows. The receiver cannot stall.
// ----------------------------------------------------------------------------
module filetime_to_dos_date_time (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_file_time,
    output logic             o_busy,
    output logic             o_done,
    output logic [15:0]      o_fat_date,
    output logic [15:0]      o_fat_time,
    output logic             o_valid_res
);

    // front end: range check and offset removal
    logic        r_s0_vld;
    logic [63:0] r_s0_ft;
    logic        r_s1_vld;
    logic        r_s1_ok;
    logic [63:0] r_s1_t;
    logic        r_s2_vld;
    logic        r_s2_ok;
    logic [47:0] r_s2_num;
    logic [64:0] c_diff;

    assign o_busy = 1'b0;
    assign c_diff = {1'b0, r_s0_ft} - {1'b0, ftdos_pkg::FT_LO};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s0_vld <= i_start && !o_busy;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_ft  <= i_file_time;
        r_s1_ok  <= !c_diff[64];
        r_s1_t   <= c_diff[63:0];
        r_s2_ok  <= r_s1_ok && (r_s1_t < ftdos_pkg::FT_SPAN);
        r_s2_num <= r_s1_t[54:7];
    end

    // seconds since 1980
    logic        d1_vld;
    logic [30:0] d1_secs;
    logic        d1_ok;

    ftdos_cdiv #(
        .DW(48), .QW(31), .RW(17), .DIV(ftdos_pkg::DIV_SUBSEC), .SPS(4), .SW(1)
    ) u_div_sec (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_s2_vld),
        .i_num  (r_s2_num),
        .i_side (r_s2_ok),
        .o_vld  (d1_vld),
        .o_quo  (d1_secs),
        .o_rem  (),
        .o_side (d1_ok)
    );

    // days and second of day
    logic        d2_vld;
    logic [14:0] d2_days;
    logic [9:0]  d2_rem;
    logic [7:0]  d2_side;
    logic [16:0] c_tod;

    ftdos_cdiv #(
        .DW(24), .QW(15), .RW(10), .DIV(ftdos_pkg::DIV_DAY), .SPS(4), .SW(8)
    ) u_div_day (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (d1_vld),
        .i_num  (d1_secs[30:7]),
        .i_side ({d1_ok, d1_secs[6:0]}),
        .o_vld  (d2_vld),
        .o_quo  (d2_days),
        .o_rem  (d2_rem),
        .o_side (d2_side)
    );

    assign c_tod = {d2_rem, d2_side[6:0]};

    // four-year blocks since 1980
    logic        d3_vld;
    logic [3:0]  d3_quad;
    logic [10:0] d3_rem;
    logic [17:0] d3_side;

    ftdos_cdiv #(
        .DW(15), .QW(4), .RW(11), .DIV(ftdos_pkg::DIV_QUAD), .SPS(4), .SW(18)
    ) u_div_quad (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (d2_vld),
        .i_num  (d2_days),
        .i_side ({d2_side[7], c_tod}),
        .o_vld  (d3_vld),
        .o_quo  (d3_quad),
        .o_rem  (d3_rem),
        .o_side (d3_side)
    );

    // hour
    logic        d4_vld;
    logic [4:0]  d4_hour;
    logic [11:0] d4_rem;
    logic [15:0] d4_side;

    ftdos_cdiv #(
        .DW(17), .QW(5), .RW(12), .DIV(ftdos_pkg::DIV_HOUR), .SPS(5), .SW(16)
    ) u_div_hour (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (d3_vld),
        .i_num  (d3_side[16:0]),
        .i_side ({d3_side[17], d3_quad, d3_rem}),
        .o_vld  (d4_vld),
        .o_quo  (d4_hour),
        .o_rem  (d4_rem),
        .o_side (d4_side)
    );

    // minute and second
    logic        d5_vld;
    logic [5:0]  d5_min;
    logic [5:0]  d5_sec;
    logic [20:0] d5_side;

    ftdos_cdiv #(
        .DW(12), .QW(6), .RW(6), .DIV(ftdos_pkg::DIV_MIN), .SPS(6), .SW(21)
    ) u_div_min (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (d4_vld),
        .i_num  (d4_rem),
        .i_side ({d4_side, d4_hour}),
        .o_vld  (d5_vld),
        .o_quo  (d5_min),
        .o_rem  (d5_sec),
        .o_side (d5_side)
    );

    // year in block, day of year, rounded half seconds
    logic                 r_sa_vld;
    ftdos_pkg::t_date_st  r_sa;
    ftdos_pkg::t_date_st  n_sa;
    logic [10:0]          c_rem;
    logic [10:0]          c_ystart;
    logic [1:0]           c_yib;
    logic [6:0]           c_sec_up;

    assign c_rem    = d5_side[15:5];
    assign c_sec_up = {1'b0, d5_sec} + 7'd1;

    always_comb begin
        if (c_rem < ftdos_pkg::QUAD_Y1) begin
            c_yib    = 2'd0;
            c_ystart = 11'd0;
        end else if (c_rem < ftdos_pkg::QUAD_Y2) begin
            c_yib    = 2'd1;
            c_ystart = ftdos_pkg::QUAD_Y1;
        end else if (c_rem < ftdos_pkg::QUAD_Y3) begin
            c_yib    = 2'd2;
            c_ystart = ftdos_pkg::QUAD_Y2;
        end else begin
            c_yib    = 2'd3;
            c_ystart = ftdos_pkg::QUAD_Y3;
        end
        n_sa.ok       = d5_side[20];
        n_sa.year_off = {d5_side[19:16], c_yib};
        n_sa.doy      = 9'(c_rem - c_ystart);
        n_sa.leap     = (c_yib == 2'd0);
        n_sa.hour     = d5_side[4:0];
        n_sa.minute   = d5_min;
        n_sa.half_sec = c_sec_up[5:1];
    end

    // month
    logic                 r_sb_vld;
    ftdos_pkg::t_date_st  r_sb;
    logic [3:0]           r_sb_mon;
    logic [3:0]           n_sb_mon;

    always_comb begin
        n_sb_mon = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (r_sa.doy >= ftdos_pkg::month_start(4'(k), r_sa.leap)) begin
                n_sb_mon = n_sb_mon + 4'd1;
            end
        end
    end

    // day of month and packing
    logic        r_done;
    logic [15:0] r_fat_date;
    logic [15:0] r_fat_time;
    logic        r_valid_res;
    logic [4:0]  c_day;

    assign c_day = 5'(r_sb.doy - ftdos_pkg::month_start(r_sb_mon, r_sb.leap) + 9'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa_vld <= 1'b0;
            r_sb_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_sa_vld <= d5_vld;
            r_sb_vld <= r_sa_vld;
            r_done   <= r_sb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa        <= n_sa;
        r_sb        <= r_sa;
        r_sb_mon    <= n_sb_mon;
        r_valid_res <= r_sb.ok;
        if (r_sb.ok) begin
            r_fat_date <= {1'b0, r_sb.year_off, r_sb_mon, c_day};
            r_fat_time <= {r_sb.hour, r_sb.minute, r_sb.half_sec};
        end else begin
            r_fat_date <= 16'd0;
            r_fat_time <= 16'd0;
        end
    end

    assign o_done      = r_done;
    assign o_fat_date  = r_fat_date;
    assign o_fat_time  = r_fat_time;
    assign o_valid_res = r_valid_res;

endmodule
`default_nettype wire

@@ rtl/ftdos_cdiv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftdos_cdiv
// Pipelined restoring divider by a constant. Up to SPS quotient bits per stage,
// sideband data and a valid bit travel with each beat. The top DW-QW bits of
// the dividend must be below DIV.
// ----------------------------------------------------------------------------
module ftdos_cdiv #(
    parameter int DW  = 48,
    parameter int QW  = 31,
    parameter int RW  = 17,
    parameter int DIV = 78125,
    parameter int SPS = 4,
    parameter int SW  = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [DW-1:0] i_num,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic [QW-1:0]      o_quo,
    output logic [RW-1:0]      o_rem,
    output logic [SW-1:0]      o_side
);

    localparam int NS = (QW + SPS - 1) / SPS;
    localparam int WW = RW + QW;
    localparam logic [RW:0] DIV_C = (RW+1)'(DIV);

    logic [NS-1:0] r_vld;
    logic [WW-1:0] r_work [NS];
    logic [SW-1:0] r_side [NS];

    logic [NS-1:0] c_vin;
    logic [WW-1:0] c_win  [NS];
    logic [SW-1:0] c_sin  [NS];
    logic [WW-1:0] n_work [NS];

    always_comb begin
        c_vin[0] = i_vld;
        c_win[0] = {RW'(i_num >> QW), i_num[QW-1:0]};
        c_sin[0] = i_side;
        for (int s = 1; s < NS; s++) begin
            c_vin[s] = r_vld[s-1];
            c_win[s] = r_work[s-1];
            c_sin[s] = r_side[s-1];
        end
    end

    always_comb begin
        logic [WW-1:0] w;
        logic [RW:0]   cand;
        logic          ge;
        for (int s = 0; s < NS; s++) begin
            w = c_win[s];
            for (int k = 0; k < SPS; k++) begin
                if (s * SPS + k < QW) begin
                    cand = w[WW-1:QW-1];
                    ge   = (cand >= DIV_C);
                    if (ge) begin
                        cand = cand - DIV_C;
                    end
                    w = {cand[RW-1:0], w[QW-2:0], ge};
                end
            end
            n_work[s] = w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= c_vin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_side <= c_sin;
    end

    assign o_vld  = r_vld[NS-1];
    assign o_quo  = r_work[NS-1][QW-1:0];
    assign o_rem  = r_work[NS-1][WW-1:QW];
    assign o_side = r_side[NS-1];

endmodule
`default_nettype wire

@@ rtl/ftdos_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftdos_chk
// Port-level checks for the FILETIME to FAT date/time converter.
// ----------------------------------------------------------------------------
module ftdos_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic [63:0] i_file_time,
    input wire logic        o_busy,
    input wire logic        o_done,
    input wire logic [15:0] o_fat_date,
    input wire logic [15:0] o_fat_time,
    input wire logic        o_valid_res
);

    localparam int LAT = ftdos_pkg::PIPE_LAT;

    // every result traces back to a beat taken a fixed latency earlier
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LAT))
        else $error("result without a matching input beat");

    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_valid_res ==
            ($past(i_file_time, LAT) >= ftdos_pkg::FT_LO &&
             $past(i_file_time, LAT) <  ftdos_pkg::FT_HI)))
        else $error("valid flag disagrees with input range");

    a_zero_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_valid_res) |-> (o_fat_date == 16'd0 && o_fat_time == 16'd0))
        else $error("rejected beat carries nonzero words");

    a_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_valid_res) |->
            (o_fat_date[4:0] != 5'd0 && o_fat_date[8:5] != 4'd0 &&
             o_fat_date[8:5] <= 4'd12 && o_fat_date[15:9] <= 7'd57 &&
             o_fat_time[4:0] <= 5'd30 && o_fat_time[10:5] <= 6'd59 &&
             o_fat_time[15:11] <= 5'd23))
        else $error("date or time field out of range");

endmodule

bind filetime_to_dos_date_time ftdos_chk u_chk (.*);
`default_nettype wire
